[rtl/swm_pkg.sv]
// Shared types, constants and helpers for the adaptive sliding-mode wrench block.
package swm_pkg;

  localparam int AXES      = 6;
  localparam int FRAC_BITS = 8;
  localparam int LANE_W    = 16;
  localparam int LANES     = 3;
  localparam int FIELD_W   = LANES * LANE_W;
  localparam int GAIN_W    = 16;
  localparam int REG_W     = 32;
  localparam int S_W       = LANE_W + GAIN_W + 2;
  localparam int EPS_W     = GAIN_W + FRAC_BITS;
  localparam int PROD_W    = GAIN_W + EPS_W;
  localparam int CNT_W     = $clog2(GAIN_W);
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_LAMBDA  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_EPS     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KBAR    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MU      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_K_INIT  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DT      = 3'd6;

  localparam logic [REG_W-1:0]  LAMBDA_RST = 32'h0A00_0A00;
  localparam logic [REG_W-1:0]  EPS_RST    = 32'h001A_001A;
  localparam logic [REG_W-1:0]  ALPHA_RST  = 32'h0003_0003;
  localparam logic [REG_W-1:0]  KBAR_RST   = 32'h0100_0100;
  localparam logic [REG_W-1:0]  MU_RST     = 32'h001A_001A;
  localparam logic [GAIN_W-1:0] K_INIT_RST = 16'd128;
  localparam logic [GAIN_W-1:0] DT_RST     = 16'd655;

  typedef struct packed {
    logic [GAIN_W-1:0] lam;
    logic [GAIN_W-1:0] eps;
    logic [GAIN_W-1:0] alpha;
    logic [GAIN_W-1:0] kbar;
    logic [GAIN_W-1:0] mu;
    logic [GAIN_W-1:0] dt;
  } swm_lane_cfg_t;

  typedef struct packed {
    logic start;
    logic clear;
  } swm_lane_ctl_t;

  typedef struct packed {
    logic              done;
    logic [LANE_W-1:0] wrench;
  } swm_lane_sts_t;

  // apply sign to a magnitude and saturate to the signed lane range
  function automatic logic [LANE_W-1:0] lane_sat(input logic neg, input logic [LANE_W-1:0] m);
    logic [LANE_W-1:0] r;
    if (neg) begin
      r = m[LANE_W-1] ? {1'b1, {(LANE_W-1){1'b0}}} : (~m + 1'b1);
    end else begin
      r = m[LANE_W-1] ? {1'b0, {(LANE_W-1){1'b1}}} : m;
    end
    return r;
  endfunction

endpackage

[rtl/swm_if.sv]
// Valid/ready channel interfaces for control samples and wrench results.
interface swm_in_if;
  logic                        valid;
  logic                        ready;
  logic [swm_pkg::FIELD_W-1:0] pose_error_lin;
  logic [swm_pkg::FIELD_W-1:0] pose_error_ang;
  logic [swm_pkg::FIELD_W-1:0] velocity_lin;
  logic [swm_pkg::FIELD_W-1:0] velocity_ang;
  logic [swm_pkg::FIELD_W-1:0] setpoint_lin;
  logic [swm_pkg::FIELD_W-1:0] setpoint_ang;

  modport source (output valid, pose_error_lin, pose_error_ang, velocity_lin, velocity_ang,
                  setpoint_lin, setpoint_ang, input ready);
  modport sink (input valid, pose_error_lin, pose_error_ang, velocity_lin, velocity_ang,
                setpoint_lin, setpoint_ang, output ready);
endinterface

interface swm_out_if;
  logic                        valid;
  logic                        ready;
  logic [swm_pkg::FIELD_W-1:0] wrench_lin;
  logic [swm_pkg::FIELD_W-1:0] wrench_ang;

  modport source (output valid, wrench_lin, wrench_ang, input ready);
  modport sink (input valid, wrench_lin, wrench_ang, output ready);
endinterface

[rtl/swm_lane.sv]
// One axis lane: sliding surface, gain adaptation and boundary-layer wrench with serial divide.
module swm_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  swm_pkg::swm_lane_cfg_t               cfg_i,
  input  logic                                 gain_load_i,
  input  logic [swm_pkg::GAIN_W-1:0]           gain_init_i,
  input  swm_pkg::swm_lane_ctl_t               ctl_i,
  input  logic signed [swm_pkg::LANE_W-1:0]    err_i,
  input  logic signed [swm_pkg::LANE_W-1:0]    vel_i,
  input  logic signed [swm_pkg::LANE_W-1:0]    sp_i,
  output swm_pkg::swm_lane_sts_t               sts_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SURF = 3'd1;
  localparam logic [2:0] ST_GAIN = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam int LW = swm_pkg::LANE_W;
  localparam int GW = swm_pkg::GAIN_W;
  localparam int SW = swm_pkg::S_W;
  localparam int EW = swm_pkg::EPS_W;
  localparam int PW = swm_pkg::PROD_W;
  localparam int FB = swm_pkg::FRAC_BITS;

  logic [2:0]                      state_q, state_d;
  logic [GW-1:0]                   k_q, k_d;
  logic [swm_pkg::CNT_W-1:0]       cnt_q, cnt_d;

  logic signed [LW-1:0]            err_q, vel_q, sp_q;
  logic signed [SW-1:0]            s_q;
  logic [GW-1:0]                   step_q, grow_q;
  logic [SW-1:0]                   mag_q;
  logic                            neg_q, big_q, zero_q;
  logic [EW-1:0]                   rem_q;
  logic [GW-1:0]                   num_q, quo_q;
  logic [LW-1:0]                   wrench_q;

  logic signed [LW:0]              diff;
  logic signed [LW+GW:0]           lam_e;
  logic signed [SW-1:0]            surf;
  logic [2*GW-1:0]                 step_full, grow_full;
  logic [SW-1:0]                   mag, muw, epsw_s;
  logic [EW-1:0]                   epsw;
  logic signed [GW+1:0]            k_adj;
  logic [GW-1:0]                   k_new;
  logic [PW-1:0]                   prod;
  logic [EW:0]                     trial, sub;
  logic                            ge;

  always_comb begin
    diff      = {sp_q[LW-1], sp_q} - {vel_q[LW-1], vel_q};
    lam_e     = $signed({1'b0, cfg_i.lam}) * err_q;
    surf      = (SW'(diff) <<< FB) + SW'(lam_e);
    step_full = cfg_i.dt * cfg_i.kbar;
    grow_full = cfg_i.dt * cfg_i.alpha;
    mag       = s_q[SW-1] ? SW'(-s_q) : SW'(s_q);
    muw       = {{(SW-EW){1'b0}}, cfg_i.mu, {FB{1'b0}}};
    epsw      = {cfg_i.eps, {FB{1'b0}}};
    epsw_s    = {{(SW-EW){1'b0}}, epsw};
    if (k_q > cfg_i.alpha) begin
      if (mag > muw) begin
        k_adj = $signed({2'b00, k_q}) + $signed({2'b00, step_q});
      end else begin
        k_adj = $signed({2'b00, k_q}) - $signed({2'b00, step_q});
      end
    end else begin
      k_adj = $signed({2'b00, k_q}) + $signed({2'b00, grow_q});
    end
    if (k_adj[GW+1]) begin
      k_new = '0;
    end else if (k_adj[GW]) begin
      k_new = '1;
    end else begin
      k_new = k_adj[GW-1:0];
    end
    prod  = k_q * mag_q[EW-1:0];
    trial = {rem_q, num_q[GW-1]};
    sub   = trial - {1'b0, epsw};
    ge    = trial >= {1'b0, epsw};
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) state_d = ST_SURF;
      end
      ST_SURF: state_d = ST_GAIN;
      ST_GAIN: begin
        k_d     = k_new;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cnt_d   = '0;
        state_d = (big_q || zero_q) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == swm_pkg::CNT_W'(GW - 1)) state_d = ST_FIN;
      end
      ST_FIN: state_d = ST_DONE;
      ST_DONE: begin
        if (ctl_i.clear) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (gain_load_i) k_d = gain_init_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= swm_pkg::K_INIT_RST;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          err_q <= err_i;
          vel_q <= vel_i;
          sp_q  <= sp_i;
        end
      end
      ST_SURF: begin
        s_q    <= surf;
        step_q <= step_full[2*GW-1:GW];
        grow_q <= grow_full[2*GW-1:GW];
      end
      ST_GAIN: begin
        mag_q  <= mag;
        neg_q  <= s_q[SW-1];
        big_q  <= mag > epsw_s;
        zero_q <= (s_q == '0);
      end
      ST_MUL: begin
        if (big_q) begin
          quo_q <= k_q;
        end else if (zero_q) begin
          quo_q <= '0;
        end else begin
          rem_q <= prod[PW-1 -: EW];
          num_q <= prod[GW-1:0];
          quo_q <= '0;
        end
      end
      ST_DIV: begin
        rem_q <= ge ? sub[EW-1:0] : trial[EW-1:0];
        num_q <= {num_q[GW-2:0], 1'b0};
        quo_q <= {quo_q[GW-2:0], ge};
      end
      ST_FIN: wrench_q <= swm_pkg::lane_sat(neg_q, quo_q);
      default: ;
    endcase
  end

  assign sts_o.done   = (state_q == ST_DONE);
  assign sts_o.wrench = wrench_q;

endmodule

[rtl/swm_merge.sv]
// Transaction control and merge of the six lane results into the output register.
module swm_merge (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  swm_pkg::swm_lane_sts_t sts_i [swm_pkg::AXES],
  output swm_pkg::swm_lane_ctl_t ctl_o,
  swm_out_if.source              out_o
);

  localparam int LW = swm_pkg::LANE_W;
  localparam int FW = swm_pkg::FIELD_W;

  logic                        busy_q, busy_d;
  logic                        ovalid_q, ovalid_d;
  logic [FW-1:0]               lin_q, ang_q;
  logic                        all_done, load, accept;
  logic [swm_pkg::AXES*LW-1:0] word;

  always_comb begin
    all_done = 1'b1;
    word     = '0;
    for (int a = 0; a < swm_pkg::AXES; a++) begin
      all_done           = all_done & sts_i[a].done;
      word[a*LW +: LW]   = sts_i[a].wrench;
    end
  end

  assign load   = busy_q && all_done && (!ovalid_q || out_o.ready);
  assign accept = in_valid_i && !busy_q;

  always_comb begin
    busy_d   = busy_q;
    ovalid_d = ovalid_q;
    if (out_o.ready) ovalid_d = 1'b0;
    if (load) begin
      busy_d   = 1'b0;
      ovalid_d = 1'b1;
    end else if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lin_q <= word[FW-1:0];
      ang_q <= word[2*FW-1:FW];
    end
  end

  assign in_ready_o       = !busy_q;
  assign ctl_o.start      = accept;
  assign ctl_o.clear      = load;
  assign out_o.valid      = ovalid_q;
  assign out_o.wrench_lin = lin_q;
  assign out_o.wrench_ang = ang_q;

endmodule

[rtl/adaptive_sliding_mode_wrench.sv]
// Top level: APB register file, six parallel axis lanes and the result merge stage.
// The serial divide is skipped when |S| > eps or S = 0; otherwise each lane runs a
// 16-step serial divide, all lanes in parallel.
// One sample in flight; the next input is accepted the cycle after the result
// is loaded into the output register.
// Reset (async, active low): registers to defaults, gains K to 0.5, channels idle.
module adaptive_sliding_mode_wrench (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  swm_in_if.sink                        in_i,
  swm_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swm_pkg::PADDR_W-1:0]   paddr,
  input  logic [swm_pkg::REG_W-1:0]     pwdata,
  output logic [swm_pkg::REG_W-1:0]     prdata,
  output logic                          pready
);

  localparam int LW = swm_pkg::LANE_W;
  localparam int GW = swm_pkg::GAIN_W;
  localparam int RW = swm_pkg::REG_W;

  logic [RW-1:0]                    lambda_q, eps_q, alpha_q, kbar_q, mu_q;
  logic [GW-1:0]                    k_init_q, dt_q;
  logic                             wr;
  logic [swm_pkg::REG_IDX_W-1:0]    idx;
  logic                             gain_load;
  logic                             in_ready;
  logic [2*swm_pkg::FIELD_W-1:0]    err_all, vel_all, sp_all;
  swm_pkg::swm_lane_ctl_t           ctl;
  swm_pkg::swm_lane_sts_t           sts [swm_pkg::AXES];

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign idx       = paddr[swm_pkg::PADDR_W-1:2];
  assign gain_load = wr && (idx == swm_pkg::REG_K_INIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= swm_pkg::LAMBDA_RST;
      eps_q    <= swm_pkg::EPS_RST;
      alpha_q  <= swm_pkg::ALPHA_RST;
      kbar_q   <= swm_pkg::KBAR_RST;
      mu_q     <= swm_pkg::MU_RST;
      k_init_q <= swm_pkg::K_INIT_RST;
      dt_q     <= swm_pkg::DT_RST;
    end else if (wr) begin
      case (idx)
        swm_pkg::REG_LAMBDA: lambda_q <= pwdata;
        swm_pkg::REG_EPS:    eps_q    <= pwdata;
        swm_pkg::REG_ALPHA:  alpha_q  <= pwdata;
        swm_pkg::REG_KBAR:   kbar_q   <= pwdata;
        swm_pkg::REG_MU:     mu_q     <= pwdata;
        swm_pkg::REG_K_INIT: k_init_q <= pwdata[GW-1:0];
        swm_pkg::REG_DT:     dt_q     <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      swm_pkg::REG_LAMBDA: prdata = lambda_q;
      swm_pkg::REG_EPS:    prdata = eps_q;
      swm_pkg::REG_ALPHA:  prdata = alpha_q;
      swm_pkg::REG_KBAR:   prdata = kbar_q;
      swm_pkg::REG_MU:     prdata = mu_q;
      swm_pkg::REG_K_INIT: prdata = {{(RW-GW){1'b0}}, k_init_q};
      swm_pkg::REG_DT:     prdata = {{(RW-GW){1'b0}}, dt_q};
      default:             prdata = '0;
    endcase
  end

  assign err_all = {in_i.pose_error_ang, in_i.pose_error_lin};
  assign vel_all = {in_i.velocity_ang, in_i.velocity_lin};
  assign sp_all  = {in_i.setpoint_ang, in_i.setpoint_lin};

  for (genvar a = 0; a < swm_pkg::AXES; a++) begin : g_lane
    localparam int H = a / swm_pkg::LANES;
    swm_pkg::swm_lane_cfg_t cfg;

    assign cfg.lam   = lambda_q[H*GW +: GW];
    assign cfg.eps   = eps_q[H*GW +: GW];
    assign cfg.alpha = alpha_q[H*GW +: GW];
    assign cfg.kbar  = kbar_q[H*GW +: GW];
    assign cfg.mu    = mu_q[H*GW +: GW];
    assign cfg.dt    = dt_q;

    swm_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg),
      .gain_load_i (gain_load),
      .gain_init_i (pwdata[GW-1:0]),
      .ctl_i       (ctl),
      .err_i       (err_all[a*LW +: LW]),
      .vel_i       (vel_all[a*LW +: LW]),
      .sp_i        (sp_all[a*LW +: LW]),
      .sts_o       (sts[a])
    );
  end

  swm_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .out_o      (out_o)
  );

  assign in_i.ready = in_ready;

endmodule

[rtl/swm_checker.sv]
// Port-level checker for the wrench block, bound to the top level.
module swm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [swm_pkg::FIELD_W-1:0] wrench_lin_i,
  input logic [swm_pkg::FIELD_W-1:0] wrench_ang_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(wrench_lin_i) && $stable(wrench_ang_i))
    else $error("result changed or dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a sample is in flight");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i ##1 !in_ready_i ##1 !in_ready_i)
    else $error("sample finished faster than the lane pipeline allows");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared with no sample in flight");

endmodule

bind adaptive_sliding_mode_wrench swm_checker u_swm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .wrench_lin_i (out_o.wrench_lin),
  .wrench_ang_i (out_o.wrench_ang)
);

[tb/sv/swm_wrench_checker.sv]
`timescale 1ns / 100ps
// Checker: models the six-axis gain adaptation and compares every wrench transaction.
module swm_wrench_checker
  import swm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  swm_in_if                  in_mon,
  swm_out_if                 out_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]   pwdata,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [FIELD_W-1:0] lin;
    logic [FIELD_W-1:0] ang;
  } wrench_t;

  logic [REG_W-1:0]  lambda_q;
  logic [REG_W-1:0]  eps_q;
  logic [REG_W-1:0]  alpha_q;
  logic [REG_W-1:0]  kbar_q;
  logic [REG_W-1:0]  mu_q;
  logic [GAIN_W-1:0] dt_q;
  logic [GAIN_W-1:0] gain_q [AXES];
  wrench_t           expected_wrench_q [$];
  int                errors;

  // Advances the per-axis gains and returns the wrench for one sample.
  function automatic wrench_t predict_wrench(input logic [FIELD_W-1:0] pe_l, pe_a, v_l, v_a,
                                             sp_l, sp_a);
    wrench_t            r;
    logic [FIELD_W-1:0] e_f, v_f, sp_f;
    logic [LANE_W-1:0]  e, v, sp;
    logic [GAIN_W-1:0]  lam, eps, alpha, kbar, mu;
    longint             s, mag, k, w, step, epsw, muw;
    int                 ln;
    r = '0;
    for (int ax = 0; ax < AXES; ax++) begin
      if (ax < LANES) begin
        e_f = pe_l; v_f = v_l; sp_f = sp_l;
        lam = lambda_q[15:0]; eps = eps_q[15:0]; alpha = alpha_q[15:0];
        kbar = kbar_q[15:0]; mu = mu_q[15:0];
      end else begin
        e_f = pe_a; v_f = v_a; sp_f = sp_a;
        lam = lambda_q[31:16]; eps = eps_q[31:16]; alpha = alpha_q[31:16];
        kbar = kbar_q[31:16]; mu = mu_q[31:16];
      end
      ln   = ax % LANES;
      e    = e_f[ln*LANE_W +: LANE_W];
      v    = v_f[ln*LANE_W +: LANE_W];
      sp   = sp_f[ln*LANE_W +: LANE_W];
      epsw = longint'(eps) << FRAC_BITS;
      muw  = longint'(mu) << FRAC_BITS;
      s    = (longint'($signed(sp)) - longint'($signed(v))) * (longint'(1) << FRAC_BITS)
             + longint'(lam) * longint'($signed(e));
      mag  = (s < 0) ? -s : s;
      k    = longint'(gain_q[ax]);
      if (k > longint'(alpha)) begin
        step = (longint'(dt_q) * longint'(kbar)) >>> 16;
        k    = (mag > muw) ? k + step : k - step;
      end else begin
        k = k + ((longint'(dt_q) * longint'(alpha)) >>> 16);
      end
      if (k < 0) k = 0;
      if (k > 65535) k = 65535;
      gain_q[ax] = k[GAIN_W-1:0];
      if (mag > epsw) w = (s > 0) ? k : -k;
      else if (s == 0) w = 0;
      else w = (k * s) / epsw;
      if (w > 32767) w = 32767;
      if (w < -32768) w = -32768;
      if (ax < LANES) r.lin[ln*LANE_W +: LANE_W] = w[LANE_W-1:0];
      else r.ang[ln*LANE_W +: LANE_W] = w[LANE_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wrench_t exp_w;
    if (!rst_ni) begin
      lambda_q = LAMBDA_RST;
      eps_q    = EPS_RST;
      alpha_q  = ALPHA_RST;
      kbar_q   = KBAR_RST;
      mu_q     = MU_RST;
      dt_q     = DT_RST;
      foreach (gain_q[i]) gain_q[i] = K_INIT_RST;
      expected_wrench_q.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[REG_IDX_W+1:2])
          REG_LAMBDA: lambda_q = pwdata;
          REG_EPS:    eps_q    = pwdata;
          REG_ALPHA:  alpha_q  = pwdata;
          REG_KBAR:   kbar_q   = pwdata;
          REG_MU:     mu_q     = pwdata;
          REG_K_INIT: begin
            foreach (gain_q[i]) gain_q[i] = pwdata[GAIN_W-1:0];
          end
          REG_DT:     dt_q     = pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_wrench_q.size() == 0) begin
          $display("%0t: unexpected wrench transaction, expected none, actual lin %h ang %h",
                   $time, out_mon.wrench_lin, out_mon.wrench_ang);
          errors++;
        end else begin
          exp_w = expected_wrench_q.pop_front();
          if (out_mon.wrench_lin !== exp_w.lin) begin
            $display("%0t: wrench_lin mismatch, expected %h, actual %h",
                     $time, exp_w.lin, out_mon.wrench_lin);
            errors++;
          end
          if (out_mon.wrench_ang !== exp_w.ang) begin
            $display("%0t: wrench_ang mismatch, expected %h, actual %h",
                     $time, exp_w.ang, out_mon.wrench_ang);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_wrench_q.push_back(predict_wrench(in_mon.pose_error_lin, in_mon.pose_error_ang,
                                                   in_mon.velocity_lin, in_mon.velocity_ang,
                                                   in_mon.setpoint_lin, in_mon.setpoint_ang));
      end
      fail_count_o <= errors;
      pending_o    <= expected_wrench_q.size();
    end
  end

endmodule

[tb/sv/adaptive_sliding_mode_wrench_tb.sv]
`timescale 1ns / 100ps
// Testbench top: drives control samples and register writes, reports the verdict.
module adaptive_sliding_mode_wrench_tb;
  import swm_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int ITEMS_PER_PHASE = 135;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [REG_W-1:0]   pwdata;
  logic [REG_W-1:0]   prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  bit                 sender_idles = 1'b1;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  adaptive_sliding_mode_wrench u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swm_wrench_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // wrench sink: random stalls, one idle-free stretch, one long hold-off
  initial begin
    int rx_cycles;
    rx_cycles = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (rx_cycles >= 9000 && rx_cycles < 9500) out_ch.ready <= 1'b0;
      else if (rx_cycles >= 2000 && rx_cycles < 5000) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(99) >= 8);
    end
  end

  function automatic logic [FIELD_W-1:0] lanes3(input logic [LANE_W-1:0] l0, l1, l2);
    return {l2, l1, l0};
  endfunction

  function automatic logic [LANE_W-1:0] rand_lane();
    logic [LANE_W-1:0] r;
    int                x;
    case ($urandom_range(9))
      0, 1, 2, 3: r = LANE_W'($urandom);
      4, 5, 6, 7: begin
        x = $urandom_range(32);
        x = x - 16;
        r = x[LANE_W-1:0];
      end
      8: r = 16'h7FFF;
      default: begin
        case ($urandom_range(3))
          0: r = 16'h8000;
          1: r = 16'hFFFF;
          2: r = 16'h0001;
          default: r = 16'h0000;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_half();
    logic [GAIN_W-1:0] r;
    case ($urandom_range(5))
      0: r = '0;
      1: r = '1;
      2: r = GAIN_W'($urandom_range(1, 64));
      3: r = GAIN_W'($urandom_range(64, 4095));
      default: r = GAIN_W'($urandom);
    endcase
    return r;
  endfunction

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_config(input logic [REG_W-1:0] lam, eps, alpha, kbar, mu,
                              input logic [GAIN_W-1:0] k_init, dt);
    apb_write(REG_LAMBDA, lam);
    apb_write(REG_EPS, eps);
    apb_write(REG_ALPHA, alpha);
    apb_write(REG_KBAR, kbar);
    apb_write(REG_MU, mu);
    apb_write(REG_K_INIT, {16'($urandom), k_init});
    apb_write(REG_DT, {16'($urandom), dt});
  endtask

  task automatic send_sample(input logic [FIELD_W-1:0] pe_l, pe_a, v_l, v_a, sp_l, sp_a);
    if (sender_idles && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.pose_error_lin <= pe_l;
    in_ch.pose_error_ang <= pe_a;
    in_ch.velocity_lin   <= v_l;
    in_ch.velocity_ang   <= v_a;
    in_ch.setpoint_lin   <= sp_l;
    in_ch.setpoint_ang   <= sp_a;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [FIELD_W-1:0] f [6];
    foreach (f[i]) f[i] = {rand_lane(), rand_lane(), rand_lane()};
    // zero pose error keeps the surface near the boundary layer more often
    if ($urandom_range(3) == 0) begin
      f[0] = '0;
      f[1] = '0;
    end
    send_sample(f[0], f[1], f[2], f[3], f[4], f[5]);
  endtask

  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [FIELD_W-1:0] mx;
    logic [FIELD_W-1:0] mn;
    mx = lanes3(16'h7FFF, 16'h7FFF, 16'h7FFF);
    mn = lanes3(16'h8000, 16'h8000, 16'h8000);
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_ch.valid          = 1'b0;
    in_ch.pose_error_lin = '0;
    in_ch.pose_error_ang = '0;
    in_ch.velocity_lin   = '0;
    in_ch.velocity_ang   = '0;
    in_ch.setpoint_lin   = '0;
    in_ch.setpoint_ang   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values
    send_sample('0, '0, '0, '0, '0, '0);
    send_sample(mx, mx, mx, mx, mx, mx);
    send_sample(mn, mn, mn, mn, mn, mn);
    send_sample(mx, mx, mn, mn, mx, mx);
    send_sample(mn, mn, mx, mx, mn, mn);
    // surface at, above and below the band
    send_sample('0, '0, '0, lanes3(16'd26, 16'd27, 16'd25), lanes3(16'd26, 16'd27, 16'd25), '0);
    // inside the boundary layer
    send_sample('0, '0, lanes3(16'h0000, 16'h0001, 16'hFFFF), lanes3(16'h0002, 16'h0000, 16'h0000),
                lanes3(16'h0001, 16'h0000, 16'h0000), lanes3(16'h0000, 16'h0000, 16'hFFFE));
    send_sample(lanes3(16'h0001, 16'hFFFF, 16'h0002), lanes3(16'hFFFF, 16'h0001, 16'h0000),
                lanes3(16'h000A, 16'h0000, 16'h0000), '0, '0, lanes3(16'h0000, 16'h0000, 16'h000A));
    send_sample(lanes3(16'h0001, 16'hFFFF, 16'h7FFF), lanes3(16'h8000, 16'h5555, 16'hAAAA),
                lanes3(16'h1234, 16'h8001, 16'h7FFE), lanes3(16'hFFFF, 16'h0000, 16'h0001),
                lanes3(16'h0100, 16'hFF00, 16'h00FF), lanes3(16'hC000, 16'h3FFF, 16'h8000));
    send_sample('0, '0, '0, '0, '0, '0);
    repeat (ITEMS_PER_PHASE) send_random();
    finish_phase();

    // zero slopes, zero boundary layer, fixed gain
    write_config('0, '0, '0, '0, '0, 16'h4000, '0);
    apb_write(REG_UNUSED, $urandom);
    send_sample('0, '0, '0, '0, '0, '0);
    send_sample('0, '0, '0, '0, lanes3(16'h0001, 16'h0000, 16'hFFFF), lanes3(16'hFFFF, 16'h0001, 16'h0));
    repeat (ITEMS_PER_PHASE) send_random();
    finish_phase();

    // everything at full scale: gain and wrench saturate
    write_config('1, '1, '1, '1, '1, '1, '1);
    send_sample(mx, mx, mx, mx, mx, mx);
    send_sample(mn, mn, mn, mn, mn, mn);
    send_sample('0, '0, '0, '0, '0, '0);
    send_sample('0, '0, '0, '0, lanes3(16'h0001, 16'h0001, 16'hFFFF),
                lanes3(16'h0001, 16'h0001, 16'hFFFF));
    repeat (ITEMS_PER_PHASE) send_random();
    finish_phase();

    // large steps push the gain update below zero, where it clamps to zero
    write_config(32'h0100_0100, 32'h0010_0010, 32'h0002_0002, '1, '1, 16'h0100, '1);
    send_sample('0, '0, '0, '0, '0, '0);
    repeat (ITEMS_PER_PHASE) send_random();
    finish_phase();

    for (int p = 0; p < 4; p++) begin
      write_config({rand_half(), rand_half()}, {rand_half(), rand_half()},
                   {rand_half(), rand_half()}, {rand_half(), rand_half()},
                   {rand_half(), rand_half()}, rand_half(), rand_half());
      sender_idles = (p != 1);
      repeat (ITEMS_PER_PHASE / 2) send_random();
      if (p == 0) finish_phase();
      repeat (ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2) send_random();
      finish_phase();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
